// ===== src/tcte_pkg.sv =====
// ----------------------------------------------------------------------------
// tcte_pkg
// Shared types and constants of the TCP connection table engine.
// ----------------------------------------------------------------------------
package tcte_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam logic [15:0] PORT_START = 16'd49152;
   localparam logic [31:0] ISN_RESET = 32'd1000;
   localparam logic [15:0] WIN_RESET = 16'd8192;
   localparam logic [15:0] MIN_SEG = 16'd20;
   localparam int Q_DEPTH = 2;

   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_CONNECT = 3'd1;
   localparam logic [2:0] OP_SEND = 3'd2;
   localparam logic [2:0] OP_CLOSE = 3'd3;
   localparam logic [2:0] OP_RECV = 3'd4;
   localparam logic [2:0] OP_TIMEOUT = 3'd5;

   localparam logic [2:0] ST_CLOSED = 3'd0;
   localparam logic [2:0] ST_SYN_SENT = 3'd1;
   localparam logic [2:0] ST_ESTAB = 3'd2;
   localparam logic [2:0] ST_LAST_ACK = 3'd5;

   localparam logic [2:0] RS_OK = 3'd0;
   localparam logic [2:0] RS_NO_FREE = 3'd1;
   localparam logic [2:0] RS_BAD_STATE = 3'd2;
   localparam logic [2:0] RS_NO_MATCH = 3'd3;
   localparam logic [2:0] RS_SHORT = 3'd4;
   localparam logic [2:0] RS_IGNORED = 3'd5;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_PSH = 8'h08;
   localparam logic [7:0] FL_ACK = 8'h10;

   localparam logic [0:0] CFG_ISN = 1'b0;
   localparam logic [0:0] CFG_WIN = 1'b1;

   localparam int REQ_W = 3 + 4 + 32 + 16 + 16 + 32 + 8 + 4 + 16;

   typedef struct packed {
      logic [15:0] length;
      logic [3:0]  data_offset;
      logic [7:0]  seg_flags;
      logic [31:0] seg_seq;
      logic [15:0] own_port;
      logic [15:0] peer_port;
      logic [31:0] peer_ip;
      logic [3:0]  slot;
      logic [2:0]  opcode;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_len;
      logic [15:0] tx_window;
      logic [31:0] tx_dst_ip;
      logic [15:0] tx_dst_port;
      logic [15:0] tx_src_port;
      logic [31:0] tx_ack;
      logic [31:0] tx_seq;
      logic [7:0]  tx_flags;
      logic [2:0]  status;
      logic [3:0]  slot_out;
   } rsp_type;

endpackage

// ===== src/tcte_front.sv =====
// ----------------------------------------------------------------------------
// tcte_front
// Input queue: accepts request words and holds them for the engine.
// ----------------------------------------------------------------------------
module tcte_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tcte_pkg::req_type in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output tcte_pkg::req_type out_word
);
   localparam int Q_DEPTH = tcte_pkg::Q_DEPTH;

   tcte_pkg::req_type q_ff [Q_DEPTH];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_word = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      rd_in = pop ? ~rd_ff : rd_ff;
      wr_in = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= in_word;
      end
   end
endmodule

// ===== src/tcte_engine.sv =====
// ----------------------------------------------------------------------------
// tcte_engine
// Connection table and sequencer: search, update and emit result words.
// ----------------------------------------------------------------------------
module tcte_engine #(
   parameter int NUM_SLOTS = tcte_pkg::NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tcte_pkg::req_type in_word,
   input  logic [31:0]       isn,
   input  logic [15:0]       win,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcte_pkg::rsp_type rsp_word,
   output logic              rsp_kind,
   output logic              rsp_last
);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_EXEC = 5'b00100,
      S_EMIT = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   tcte_pkg::req_type req_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [SW-1:0] hit_ff, hit_in;

   logic used_ff [NUM_SLOTS];
   logic [2:0] cst_ff [NUM_SLOTS];
   logic [31:0] raddr_ff [NUM_SLOTS];
   logic [15:0] lport_ff [NUM_SLOTS];
   logic [15:0] rport_ff [NUM_SLOTS];
   logic [31:0] sseq_ff [NUM_SLOTS];
   logic [31:0] rack_ff [NUM_SLOTS];
   logic [15:0] nport_ff;

   // pending results: up to two segments then status
   logic [1:0] nseg_ff;
   logic [7:0] f0_ff, f1_ff;
   logic [31:0] seq0_ff, seq1_ff, ack_ff;
   logic [3:0] os_ff;
   logic [2:0] ost_ff;
   logic [15:0] oport_ff, plen_ff;
   logic [15:0] dport_ff;
   logic [31:0] dip_ff;
   logic [15:0] sport_ff;
   logic [1:0] k_ff;

   logic [SW-1:0] sc;
   logic [SW-1:0] ssel;
   logic [SW-1:0] upd;
   logic scan_hit, in_rng;
   logic [15:0] hlen, dlen;
   logic [31:0] seqp1, seqpd;

   logic [1:0] nseg_in;
   logic [7:0] f0_in, f1_in;
   logic [31:0] ack_in, dip_in, sseq_val, rack_val;
   logic [3:0] os_in;
   logic [2:0] ost_in, cst_val;
   logic [15:0] oport_in, plen_in, dport_in;
   logic used_we, used_val, cst_we, lport_we, sseq_we, rack_we, rmt_we, nport_we;

   assign in_ready = (st_ff == S_IDLE);
   assign sc = idx_ff[SW-1:0];
   assign ssel = req_ff.opcode == tcte_pkg::OP_RECV ? hit_ff : SW'(req_ff.slot);
   assign upd = req_ff.opcode == tcte_pkg::OP_ALLOC ? hit_ff : ssel;
   assign in_rng = ({28'd0, req_ff.slot} < 32'(NUM_SLOTS));
   assign scan_hit = (idx_ff < CW'(NUM_SLOTS)) && (req_ff.opcode == tcte_pkg::OP_ALLOC ?
      !used_ff[sc] : (used_ff[sc] && raddr_ff[sc] == req_ff.peer_ip &&
      rport_ff[sc] == req_ff.peer_port && lport_ff[sc] == req_ff.own_port));
   assign hlen = {10'd0, req_ff.data_offset, 2'b00};
   assign dlen = (req_ff.length > hlen) ? req_ff.length - hlen : 16'd0;
   assign seqp1 = req_ff.seg_seq + 32'd1;
   assign seqpd = req_ff.seg_seq + {16'd0, dlen};

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      case (st_ff)
         S_IDLE: begin
            idx_in = '0;
            found_in = 1'b0;
            if (in_valid) st_in = S_SCAN;
         end
         S_SCAN: begin
            if (req_ff.opcode != tcte_pkg::OP_ALLOC && req_ff.opcode != tcte_pkg::OP_RECV) begin
               st_in = S_EXEC;
            end else if (scan_hit) begin
               found_in = 1'b1;
               hit_in = sc;
               st_in = S_EXEC;
            end else if (idx_ff >= CW'(NUM_SLOTS)) begin
               st_in = S_EXEC;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_EXEC: st_in = S_EMIT;
         S_EMIT: if (rsp_ready && k_ff == nseg_ff) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // decide results and table updates of the current request
   always_comb begin
      nseg_in = 2'd0;
      f0_in = '0;
      f1_in = '0;
      ack_in = rack_ff[ssel];
      os_in = req_ff.slot;
      ost_in = tcte_pkg::RS_OK;
      oport_in = '0;
      plen_in = '0;
      dip_in = raddr_ff[ssel];
      dport_in = rport_ff[ssel];
      used_we = 1'b0;
      used_val = 1'b0;
      cst_we = 1'b0;
      cst_val = tcte_pkg::ST_CLOSED;
      lport_we = 1'b0;
      sseq_we = 1'b0;
      sseq_val = sseq_ff[ssel];
      rack_we = 1'b0;
      rack_val = seqp1;
      rmt_we = 1'b0;
      nport_we = 1'b0;
      case (req_ff.opcode)
         tcte_pkg::OP_ALLOC: begin
            if (found_ff) begin
               used_we = 1'b1;
               used_val = 1'b1;
               cst_we = 1'b1;
               cst_val = tcte_pkg::ST_CLOSED;
               lport_we = 1'b1;
               sseq_we = 1'b1;
               sseq_val = isn;
               nport_we = 1'b1;
               os_in = 4'(hit_ff);
               oport_in = nport_ff;
            end else begin
               os_in = '0;
               ost_in = tcte_pkg::RS_NO_FREE;
            end
         end
         tcte_pkg::OP_RECV: begin
            os_in = 4'(hit_ff);
            ost_in = tcte_pkg::RS_IGNORED;
            if (req_ff.length < tcte_pkg::MIN_SEG) begin
               os_in = '0;
               ost_in = tcte_pkg::RS_SHORT;
            end else if (!found_ff) begin
               os_in = '0;
               ost_in = tcte_pkg::RS_NO_MATCH;
            end else if (cst_ff[hit_ff] == tcte_pkg::ST_SYN_SENT) begin
               if ((req_ff.seg_flags & tcte_pkg::FL_SYN) != 0 &&
                   (req_ff.seg_flags & tcte_pkg::FL_ACK) != 0) begin
                  rack_we = 1'b1;
                  rack_val = seqp1;
                  ack_in = seqp1;
                  cst_we = 1'b1;
                  cst_val = tcte_pkg::ST_ESTAB;
                  nseg_in = 2'd1;
                  f0_in = tcte_pkg::FL_ACK;
                  ost_in = tcte_pkg::RS_OK;
               end
            end else if (cst_ff[hit_ff] == tcte_pkg::ST_ESTAB) begin
               if ((req_ff.seg_flags & tcte_pkg::FL_FIN) != 0) begin
                  rack_we = 1'b1;
                  rack_val = seqp1;
                  ack_in = seqp1;
                  sseq_we = 1'b1;
                  sseq_val = sseq_ff[hit_ff] + 32'd1;
                  cst_we = 1'b1;
                  cst_val = tcte_pkg::ST_LAST_ACK;
                  nseg_in = 2'd2;
                  f0_in = tcte_pkg::FL_ACK;
                  f1_in = tcte_pkg::FL_FIN | tcte_pkg::FL_ACK;
                  ost_in = tcte_pkg::RS_OK;
               end else if ((req_ff.seg_flags & tcte_pkg::FL_ACK) != 0 &&
                            dlen != 0) begin
                  rack_we = 1'b1;
                  rack_val = seqpd;
                  ack_in = seqpd;
                  nseg_in = 2'd1;
                  f0_in = tcte_pkg::FL_ACK;
                  plen_in = dlen;
                  ost_in = tcte_pkg::RS_OK;
               end
            end else if (cst_ff[hit_ff] == tcte_pkg::ST_LAST_ACK) begin
               if ((req_ff.seg_flags & tcte_pkg::FL_ACK) != 0) begin
                  cst_we = 1'b1;
                  cst_val = tcte_pkg::ST_CLOSED;
                  ost_in = tcte_pkg::RS_OK;
               end
            end
         end
         tcte_pkg::OP_CONNECT, tcte_pkg::OP_SEND, tcte_pkg::OP_CLOSE,
         tcte_pkg::OP_TIMEOUT: begin
            if (!in_rng) begin
               ost_in = tcte_pkg::RS_BAD_STATE;
            end else if (req_ff.opcode == tcte_pkg::OP_CONNECT) begin
               if (!used_ff[ssel] || cst_ff[ssel] != tcte_pkg::ST_CLOSED) begin
                  ost_in = tcte_pkg::RS_BAD_STATE;
               end else begin
                  rmt_we = 1'b1;
                  dip_in = req_ff.peer_ip;
                  dport_in = req_ff.peer_port;
                  cst_we = 1'b1;
                  cst_val = tcte_pkg::ST_SYN_SENT;
                  sseq_we = 1'b1;
                  sseq_val = sseq_ff[ssel] + 32'd1;
                  ack_in = '0;
                  nseg_in = 2'd1;
                  f0_in = tcte_pkg::FL_SYN;
               end
            end else if (req_ff.opcode == tcte_pkg::OP_SEND) begin
               if (cst_ff[ssel] != tcte_pkg::ST_ESTAB) begin
                  ost_in = tcte_pkg::RS_BAD_STATE;
               end else begin
                  sseq_we = 1'b1;
                  sseq_val = sseq_ff[ssel] + {16'd0, req_ff.length};
                  nseg_in = 2'd1;
                  f0_in = tcte_pkg::FL_PSH | tcte_pkg::FL_ACK;
               end
            end else if (req_ff.opcode == tcte_pkg::OP_CLOSE) begin
               if (cst_ff[ssel] == tcte_pkg::ST_ESTAB) begin
                  sseq_we = 1'b1;
                  sseq_val = sseq_ff[ssel] + 32'd1;
                  nseg_in = 2'd1;
                  f0_in = tcte_pkg::FL_FIN | tcte_pkg::FL_ACK;
               end
               used_we = 1'b1;
               used_val = 1'b0;
               cst_we = 1'b1;
               cst_val = tcte_pkg::ST_CLOSED;
            end else begin
               if (cst_ff[ssel] != tcte_pkg::ST_SYN_SENT) begin
                  ost_in = tcte_pkg::RS_BAD_STATE;
               end else begin
                  cst_we = 1'b1;
                  cst_val = tcte_pkg::ST_CLOSED;
               end
            end
         end
         default: ost_in = tcte_pkg::RS_IGNORED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         nport_ff <= tcte_pkg::PORT_START;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            used_ff[i] <= 1'b0;
            cst_ff[i] <= tcte_pkg::ST_CLOSED;
         end
         k_ff <= 2'd0;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         hit_ff <= hit_in;
         if (st_ff == S_IDLE && in_valid) req_ff <= in_word;
         if (st_ff == S_EMIT && rsp_ready) k_ff <= k_ff + 2'd1;
         if (st_ff == S_EXEC) begin
            k_ff <= 2'd0;
            nseg_ff <= nseg_in;
            os_ff <= os_in;
            ost_ff <= ost_in;
            oport_ff <= oport_in;
            plen_ff <= plen_in;
            ack_ff <= ack_in;
            seq0_ff <= sseq_ff[ssel];
            seq1_ff <= sseq_ff[ssel];
            sport_ff <= lport_ff[ssel];
            dport_ff <= dport_in;
            dip_ff <= dip_in;
            f0_ff <= f0_in;
            f1_ff <= f1_in;
            if (used_we) used_ff[upd] <= used_val;
            if (cst_we) cst_ff[upd] <= cst_val;
            if (lport_we) lport_ff[upd] <= nport_ff;
            if (sseq_we) sseq_ff[upd] <= sseq_val;
            if (rack_we) rack_ff[upd] <= rack_val;
            if (rmt_we) begin
               raddr_ff[upd] <= req_ff.peer_ip;
               rport_ff[upd] <= req_ff.peer_port;
            end
            if (nport_we) nport_ff <= nport_ff + 16'd1;
         end
      end
   end

   always_comb begin
      rsp_valid = (st_ff == S_EMIT);
      rsp_last = (k_ff == nseg_ff);
      rsp_kind = !rsp_last;
      rsp_word = '0;
      rsp_word.slot_out = os_ff;
      if (rsp_last) begin
         rsp_word.status = ost_ff;
         rsp_word.tx_src_port = oport_ff;
         rsp_word.payload_len = plen_ff;
      end else begin
         rsp_word.tx_flags = (k_ff == 2'd0) ? f0_ff : f1_ff;
         rsp_word.tx_seq = (k_ff == 2'd0) ? seq0_ff : seq1_ff;
         rsp_word.tx_ack = ack_ff;
         rsp_word.tx_src_port = sport_ff;
         rsp_word.tx_dst_port = dport_ff;
         rsp_word.tx_dst_ip = dip_ff;
         rsp_word.tx_window = win;
      end
   end
endmodule

// ===== src/tcp_connection_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_table_engine_unit
// TCP connection table with a request queue in front of the table engine.
// ----------------------------------------------------------------------------
// Allocate and receive run a sequential table search that stops at the first
// fitting slot and walks every slot when nothing fits; the other operations
// address their slot directly. A two-entry queue takes new requests while the
// engine works. Each request gives 1 to 3 result words, the last being the
// status word with tlast set.
module tcp_connection_table_engine_unit #(
   parameter int NUM_SLOTS = tcte_pkg::NUM_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode, slot, peer_ip, peer_port, own_port, seg_seq, seg_flags,
   // data_offset, length, 5 zero pad bits
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_out, status, tx_flags, tx_seq, tx_ack, tx_src_port, tx_dst_port,
   // tx_dst_ip, tx_window, payload_len, 1 zero pad bit
   output logic [175:0] rsp_tdata,
   output logic         rsp_tuser, // kind
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);
   tcte_pkg::req_type qw, iw;
   tcte_pkg::rsp_type ow;
   logic qv, qr;
   logic [31:0] isn_ff;
   logic [15:0] win_ff;

   assign iw = req_tdata[tcte_pkg::REQ_W-1:0];
   assign csr_ready = 1'b1;
   assign rsp_tdata = {1'b0, ow};

   always_ff @(posedge clock) begin
      if (reset) begin
         isn_ff <= tcte_pkg::ISN_RESET;
         win_ff <= tcte_pkg::WIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tcte_pkg::CFG_ISN: isn_ff <= csr_data;
            tcte_pkg::CFG_WIN: win_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   tcte_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_word(iw),
      .out_valid(qv), .out_ready(qr), .out_word(qw)
   );

   tcte_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
      .clock(clock), .reset(reset),
      .in_valid(qv), .in_ready(qr), .in_word(qw),
      .isn(isn_ff), .win(win_ff),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_word(ow),
      .rsp_kind(rsp_tuser), .rsp_last(rsp_tlast)
   );
endmodule

// ===== src/tcte_checker.sv =====
// ----------------------------------------------------------------------------
// tcte_checker
// Port-level checks of the connection table engine.
// ----------------------------------------------------------------------------
module tcte_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [175:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != rsp_tlast))
      else $error("kind and last disagree");
   a_seg_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[6:4] == 3'd0)
      else $error("segment word carries a status");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");
endmodule

bind tcp_connection_table_engine_unit tcte_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);

// ===== sim/tcp_connection_table_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_connection_table_engine_unit_tb
// Self-checking bench for the TCP connection table engine. A directed table
// walks reset values, field extremes, error codes and one full connection
// life cycle. Random traffic follows, mostly well-formed handshakes, data and
// teardown on live slots, with noise mixed in, under four register settings.
// Every result word is checked against a behavioral table model.
// ----------------------------------------------------------------------------
module tcp_connection_table_engine_unit_tb;

   localparam int SLOTS = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic              kind;
      logic              last;
      tcte_pkg::rsp_type w;
   } tcp_word_type;

   typedef struct {
      tcte_pkg::req_type r;
      bit                typed;
      logic [2:0]        st;
      logic [3:0]        sl;
      logic [15:0]       port;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [175:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [31:0]  csr_data;

   tcp_word_type pending_words[$];
   dir_row_type  dir_rows[$];
   bit        failed;
   bit        no_stall;
   int        idle_cycles;
   int        stall_left;

   // table model
   logic [31:0] isn_cfg;
   logic [15:0] win_cfg;
   bit          used_tab[SLOTS];
   bit          addr_known[SLOTS];
   logic [2:0]  state_tab[SLOTS];
   logic [31:0] raddr_tab[SLOTS];
   logic [15:0] lport_tab[SLOTS];
   logic [15:0] rport_tab[SLOTS];
   logic [31:0] seq_tab[SLOTS];
   logic [31:0] ack_tab[SLOTS];
   logic [15:0] port_next;

   tcp_connection_table_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void push_segment(int s, logic [7:0] fl, logic [31:0] ack);
      tcp_word_type t;
      t.kind = 1'b1;
      t.last = 1'b0;
      t.w = '0;
      t.w.slot_out = s[3:0];
      t.w.tx_flags = fl;
      t.w.tx_seq = seq_tab[s];
      t.w.tx_ack = ack;
      t.w.tx_src_port = lport_tab[s];
      t.w.tx_dst_port = rport_tab[s];
      t.w.tx_dst_ip = raddr_tab[s];
      t.w.tx_window = win_cfg;
      pending_words.push_back(t);
   endfunction

   function automatic void push_status(int s, logic [2:0] st, logic [15:0] port,
                                       logic [15:0] plen);
      tcp_word_type t;
      t.kind = 1'b0;
      t.last = 1'b1;
      t.w = '0;
      t.w.slot_out = s[3:0];
      t.w.status = st;
      t.w.tx_src_port = port;
      t.w.payload_len = plen;
      pending_words.push_back(t);
   endfunction

   function automatic void table_reset();
      isn_cfg = tcte_pkg::ISN_RESET;
      win_cfg = tcte_pkg::WIN_RESET;
      port_next = tcte_pkg::PORT_START;
      for (int i = 0; i < SLOTS; i++) begin
         used_tab[i] = 0;
         addr_known[i] = 0;
         state_tab[i] = tcte_pkg::ST_CLOSED;
      end
   endfunction

   function automatic void segment_arrival(tcte_pkg::req_type r);
      int s;
      logic [16:0] hlen;
      logic [15:0] dlen;
      s = -1;
      if (r.length < tcte_pkg::MIN_SEG) begin
         push_status(0, tcte_pkg::RS_SHORT, 0, 0);
         return;
      end
      for (int i = 0; i < SLOTS; i++)
         if (s < 0 && used_tab[i] && raddr_tab[i] == r.peer_ip &&
             rport_tab[i] == r.peer_port && lport_tab[i] == r.own_port)
            s = i;
      if (s < 0) begin
         push_status(0, tcte_pkg::RS_NO_MATCH, 0, 0);
         return;
      end
      hlen = {11'd0, r.data_offset, 2'b00};
      dlen = ({1'b0, r.length} > hlen) ? r.length - hlen[15:0] : 16'd0;
      case (state_tab[s])
         tcte_pkg::ST_SYN_SENT: begin
            if ((r.seg_flags & tcte_pkg::FL_SYN) != 0 &&
                (r.seg_flags & tcte_pkg::FL_ACK) != 0) begin
               ack_tab[s] = r.seg_seq + 32'd1;
               state_tab[s] = tcte_pkg::ST_ESTAB;
               push_segment(s, tcte_pkg::FL_ACK, ack_tab[s]);
               push_status(s, tcte_pkg::RS_OK, 0, 0);
               return;
            end
         end
         tcte_pkg::ST_ESTAB: begin
            if ((r.seg_flags & tcte_pkg::FL_FIN) != 0) begin
               ack_tab[s] = r.seg_seq + 32'd1;
               push_segment(s, tcte_pkg::FL_ACK, ack_tab[s]);
               push_segment(s, tcte_pkg::FL_FIN | tcte_pkg::FL_ACK, ack_tab[s]);
               seq_tab[s] += 32'd1;
               state_tab[s] = tcte_pkg::ST_LAST_ACK;
               push_status(s, tcte_pkg::RS_OK, 0, 0);
               return;
            end
            if ((r.seg_flags & tcte_pkg::FL_ACK) != 0 && dlen > 0) begin
               ack_tab[s] = r.seg_seq + {16'd0, dlen};
               push_segment(s, tcte_pkg::FL_ACK, ack_tab[s]);
               push_status(s, tcte_pkg::RS_OK, 0, dlen);
               return;
            end
         end
         tcte_pkg::ST_LAST_ACK: begin
            if ((r.seg_flags & tcte_pkg::FL_ACK) != 0) begin
               state_tab[s] = tcte_pkg::ST_CLOSED;
               push_status(s, tcte_pkg::RS_OK, 0, 0);
               return;
            end
         end
         default: ;
      endcase
      push_status(s, tcte_pkg::RS_IGNORED, 0, 0);
   endfunction

   function automatic void table_step(tcte_pkg::req_type r);
      int s;
      s = r.slot;
      if (r.opcode == tcte_pkg::OP_ALLOC) begin
         for (int i = 0; i < SLOTS; i++)
            if (!used_tab[i]) begin
               used_tab[i] = 1;
               state_tab[i] = tcte_pkg::ST_CLOSED;
               lport_tab[i] = port_next;
               port_next = port_next + 16'd1;
               seq_tab[i] = isn_cfg;
               push_status(i, tcte_pkg::RS_OK, lport_tab[i], 0);
               return;
            end
         push_status(0, tcte_pkg::RS_NO_FREE, 0, 0);
         return;
      end
      case (r.opcode)
         tcte_pkg::OP_RECV: segment_arrival(r);
         tcte_pkg::OP_CONNECT: begin
            if (!used_tab[s] || state_tab[s] != tcte_pkg::ST_CLOSED)
               push_status(s, tcte_pkg::RS_BAD_STATE, 0, 0);
            else begin
               raddr_tab[s] = r.peer_ip;
               rport_tab[s] = r.peer_port;
               addr_known[s] = 1;
               state_tab[s] = tcte_pkg::ST_SYN_SENT;
               push_segment(s, tcte_pkg::FL_SYN, 0);
               seq_tab[s] += 32'd1;
               push_status(s, tcte_pkg::RS_OK, 0, 0);
            end
         end
         tcte_pkg::OP_SEND: begin
            if (state_tab[s] != tcte_pkg::ST_ESTAB)
               push_status(s, tcte_pkg::RS_BAD_STATE, 0, 0);
            else begin
               push_segment(s, tcte_pkg::FL_PSH | tcte_pkg::FL_ACK, ack_tab[s]);
               seq_tab[s] += {16'd0, r.length};
               push_status(s, tcte_pkg::RS_OK, 0, 0);
            end
         end
         tcte_pkg::OP_CLOSE: begin
            if (state_tab[s] == tcte_pkg::ST_ESTAB) begin
               push_segment(s, tcte_pkg::FL_FIN | tcte_pkg::FL_ACK, ack_tab[s]);
               seq_tab[s] += 32'd1;
            end
            used_tab[s] = 0;
            state_tab[s] = tcte_pkg::ST_CLOSED;
            push_status(s, tcte_pkg::RS_OK, 0, 0);
         end
         tcte_pkg::OP_TIMEOUT: begin
            if (state_tab[s] != tcte_pkg::ST_SYN_SENT)
               push_status(s, tcte_pkg::RS_BAD_STATE, 0, 0);
            else begin
               state_tab[s] = tcte_pkg::ST_CLOSED;
               push_status(s, tcte_pkg::RS_OK, 0, 0);
            end
         end
         default: push_status(s, tcte_pkg::RS_IGNORED, 0, 0);
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
         failed = 1;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      tcp_word_type e;
      tcte_pkg::rsp_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = tcte_pkg::rsp_type'(rsp_tdata[174:0]);
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
            failed = 1;
         end else begin
            e = pending_words.pop_front();
            check_field("kind", e.kind, rsp_tuser);
            check_field("last", e.last, rsp_tlast);
            check_field("slot_out", e.w.slot_out, a.slot_out);
            check_field("status", e.w.status, a.status);
            check_field("tx_flags", e.w.tx_flags, a.tx_flags);
            check_field("tx_seq", e.w.tx_seq, a.tx_seq);
            check_field("tx_ack", e.w.tx_ack, a.tx_ack);
            check_field("tx_src_port", e.w.tx_src_port, a.tx_src_port);
            check_field("tx_dst_port", e.w.tx_dst_port, a.tx_dst_port);
            check_field("tx_dst_ip", e.w.tx_dst_ip, a.tx_dst_ip);
            check_field("tx_window", e.w.tx_window, a.tx_window);
            check_field("payload_len", e.w.payload_len, a.payload_len);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[tcp_connection_table_engine_unit] ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic int rand_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // result stall
   always @(negedge clock) begin
      if (no_stall || stall_left == 0) begin
         rsp_tready <= 1'b1;
         stall_left <= no_stall ? 0 : rand_gap();
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   task automatic send_word(tcte_pkg::req_type r, bit typed, logic [2:0] st,
                            logic [3:0] sl, logic [15:0] port);
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, r};
      do @(posedge clock); while (!req_tready);
      table_step(r);
      if (typed) begin
         void'(pending_words.pop_back());
         push_status(sl, st, port, 0);
      end
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int n;
      n = no_stall ? 0 : rand_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending_words.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == tcte_pkg::CFG_ISN) isn_cfg = val;
      else win_cfg = val[15:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(logic [2:0] op, logic [3:0] sl, logic [31:0] ip,
                                   logic [15:0] pp, logic [15:0] op_port,
                                   logic [31:0] sq, logic [7:0] fl, logic [3:0] doff,
                                   logic [15:0] len, bit typed, logic [2:0] st,
                                   logic [3:0] esl, logic [15:0] eport);
      dir_row_type d;
      d.r = '{length: len, data_offset: doff, seg_flags: fl, seg_seq: sq,
              own_port: op_port, peer_port: pp, peer_ip: ip, slot: sl, opcode: op};
      d.typed = typed;
      d.st = st;
      d.sl = esl;
      d.port = eport;
      dir_rows.push_back(d);
   endfunction

   function automatic int pick_slot(bit want_used, bit any_state, logic [2:0] st);
      int c[$];
      for (int i = 0; i < SLOTS; i++)
         if (used_tab[i] == want_used && (any_state || state_tab[i] == st) &&
             (!want_used || addr_known[i] || st == tcte_pkg::ST_CLOSED))
            c.push_back(i);
      if (c.size() == 0) return -1;
      return c[$urandom_range(0, c.size() - 1)];
   endfunction

   function automatic tcte_pkg::req_type random_word();
      tcte_pkg::req_type r;
      int p, s;
      bit safe;
      r = tcte_pkg::req_type'(tcte_pkg::REQ_W'({$urandom, $urandom, $urandom,
                                                $urandom, $urandom}));
      safe = 1;
      for (int i = 0; i < SLOTS; i++)
         if (used_tab[i] && !addr_known[i]) safe = 0;
      p = $urandom_range(0, 99);
      if (p < 12) r.opcode = tcte_pkg::OP_ALLOC;
      else if (p < 26) begin
         r.opcode = tcte_pkg::OP_CONNECT;
         s = pick_slot(1, 0, tcte_pkg::ST_CLOSED);
         if (s >= 0 && $urandom_range(0, 4) != 0) r.slot = 4'(s);
      end else if (p < 38) begin
         r.opcode = tcte_pkg::OP_SEND;
         s = pick_slot(1, 0, tcte_pkg::ST_ESTAB);
         if (s >= 0 && $urandom_range(0, 4) != 0) r.slot = 4'(s);
         if ($urandom_range(0, 3) != 0) r.length = 16'($urandom_range(0, 1500));
      end else if (p < 46) begin
         r.opcode = tcte_pkg::OP_CLOSE;
         s = pick_slot(1, 1, tcte_pkg::ST_CLOSED);
         if (s >= 0 && $urandom_range(0, 3) != 0) r.slot = 4'(s);
      end else if (p < 51) begin
         r.opcode = tcte_pkg::OP_TIMEOUT;
         s = pick_slot(1, 0, tcte_pkg::ST_SYN_SENT);
         if (s >= 0 && $urandom_range(0, 2) != 0) r.slot = 4'(s);
      end else if (p < 93) begin
         r.opcode = tcte_pkg::OP_RECV;
         s = pick_slot(1, 1, tcte_pkg::ST_CLOSED);
         if (safe && s >= 0 && $urandom_range(0, 4) != 0) begin
            r.peer_ip = raddr_tab[s];
            r.peer_port = rport_tab[s];
            r.own_port = lport_tab[s];
            if ($urandom_range(0, 3) != 0) begin
               r.data_offset = 4'd5;
               r.length = 16'($urandom_range(20, 1500));
            end
            if ($urandom_range(0, 4) != 0)
               case (state_tab[s])
                  tcte_pkg::ST_SYN_SENT: r.seg_flags = tcte_pkg::FL_SYN | tcte_pkg::FL_ACK;
                  tcte_pkg::ST_ESTAB: r.seg_flags = ($urandom_range(0, 3) == 0) ?
                     (tcte_pkg::FL_FIN | tcte_pkg::FL_ACK) :
                     (tcte_pkg::FL_PSH | tcte_pkg::FL_ACK);
                  default: r.seg_flags = tcte_pkg::FL_ACK;
               endcase
         end
      end
      // keep segments away from slots whose remote end was never set
      if (r.opcode == tcte_pkg::OP_RECV && !safe)
         r.length = 16'($urandom_range(0, 19));
      return r;
   endfunction

   initial begin
      failed = 0;
      no_stall = 0;
      stall_left = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = tcte_pkg::CFG_ISN;
      csr_data = '0;
      table_reset();

      add_row(tcte_pkg::OP_RECV, 0, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_SHORT, 0, 0);
      add_row(tcte_pkg::OP_RECV, 15, '1, '1, '1, '1, '1, '1, 19, 1,
              tcte_pkg::RS_SHORT, 0, 0);
      add_row(tcte_pkg::OP_RECV, 0, 0, 0, 0, 0, tcte_pkg::FL_ACK, 5, 20, 1,
              tcte_pkg::RS_NO_MATCH, 0, 0);
      add_row(tcte_pkg::OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 1,
              tcte_pkg::RS_BAD_STATE, 0, 0);
      add_row(tcte_pkg::OP_SEND, 15, 0, 0, 0, 0, 0, 0, 0, 1,
              tcte_pkg::RS_BAD_STATE, 15, 0);
      add_row(tcte_pkg::OP_TIMEOUT, 7, 0, 0, 0, 0, 0, 0, 0, 1,
              tcte_pkg::RS_BAD_STATE, 7, 0);
      add_row(tcte_pkg::OP_CLOSE, 15, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_OK, 15, 0);
      add_row(3'd6, 9, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_IGNORED, 9, 0);
      add_row(3'd7, 15, '1, '1, '1, '1, '1, '1, '1, 1, tcte_pkg::RS_IGNORED, 15, 0);
      add_row(tcte_pkg::OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_OK, 0,
              tcte_pkg::PORT_START);
      add_row(tcte_pkg::OP_ALLOC, 5, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_OK, 1,
              tcte_pkg::PORT_START + 16'd1);
      add_row(tcte_pkg::OP_CONNECT, 0, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_CONNECT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_RECV, 0, '1, '1, tcte_pkg::PORT_START, '1,
              tcte_pkg::FL_SYN | tcte_pkg::FL_ACK, 5, 20, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_RECV, 0, '1, '1, tcte_pkg::PORT_START, 7,
              tcte_pkg::FL_ACK, 15, 40, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_RECV, 0, '1, '1, tcte_pkg::PORT_START, 100,
              tcte_pkg::FL_PSH | tcte_pkg::FL_ACK, 0, '1, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_SEND, 0, 0, 0, 0, 0, 0, 0, '1, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_SEND, 1, 0, 0, 0, 0, 0, 0, 1, 1,
              tcte_pkg::RS_BAD_STATE, 1, 0);
      add_row(tcte_pkg::OP_TIMEOUT, 1, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_OK, 1, 0);
      add_row(tcte_pkg::OP_RECV, 0, '1, '1, tcte_pkg::PORT_START, 0,
              tcte_pkg::FL_FIN, 5, 20, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_RECV, 0, '1, '1, tcte_pkg::PORT_START, 0, 0, 5, 20,
              0, 0, 0, 0);
      add_row(tcte_pkg::OP_RECV, 0, '1, '1, tcte_pkg::PORT_START, 0,
              tcte_pkg::FL_ACK, 5, 20, 0, 0, 0, 0);
      add_row(tcte_pkg::OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_OK, 0, 0);
      add_row(tcte_pkg::OP_CLOSE, 1, 0, 0, 0, 0, 0, 0, 0, 1, tcte_pkg::RS_OK, 1, 0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].sl,
                   dir_rows[i].port);
         sender_gap();
      end

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: ;
            1: begin
               write_reg(tcte_pkg::CFG_ISN, '1);
               write_reg(tcte_pkg::CFG_WIN, '0);
            end
            2: begin
               write_reg(tcte_pkg::CFG_ISN, '0);
               write_reg(tcte_pkg::CFG_WIN, 32'h0000_FFFF);
            end
            default: begin
               write_reg(tcte_pkg::CFG_WIN, $urandom);
               write_reg(tcte_pkg::CFG_ISN, $urandom);
            end
         endcase
         no_stall = (ph == 2);
         for (int n = 0; n < 108; n++) begin
            send_word(random_word(), 0, 0, 0, 0);
            sender_gap();
         end
      end

      req_tvalid <= 1'b0;
      wait (pending_words.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("[tcp_connection_table_engine_unit] OK");
      else
         $display("[tcp_connection_table_engine_unit] ERROR");
      $finish;
   end

endmodule
